// ===== hdl/pipe_health_monitor_assert.svh =====
// ---------------------------------------------------------------------------
// pipe_health_monitor_assert.svh
// Assertion macros used by phm_state in the health monitor RTL.
// ---------------------------------------------------------------------------
`ifndef PIPE_HEALTH_MONITOR_ASSERT_SVH
`define PIPE_HEALTH_MONITOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PHM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/phm_pkg.sv =====
// ---------------------------------------------------------------------------
// phm_pkg
// Types and constants shared by the pipe health monitor.
// ---------------------------------------------------------------------------
package phm_pkg;

	// health codes
	localparam logic [1:0] HEALTH_HEALTHY    = 2'd0;
	localparam logic [1:0] HEALTH_DISTRESSED = 2'd1;
	localparam logic [1:0] HEALTH_HARD       = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_QUEUE_SIZE_LOG2 = 2'd0;
	localparam logic [1:0] CFG_DISTRESSED_PCT  = 2'd1;
	localparam logic [1:0] CFG_RECOVERED_PCT   = 2'd2;
	localparam logic [1:0] CFG_DEADLINE_MS     = 2'd3;

	localparam logic [6:0] PCT_CAP = 7'd100;
	localparam int PROD_W = 23; // 16-bit fill times 100

	typedef struct packed {
		logic [3:0]  queue_size_log2;
		logic [6:0]  distressed_pct;
		logic [6:0]  recovered_pct;
		logic [31:0] deadline_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0]       now_ms;
		logic [PROD_W-1:0] fill_x100;
		logic [15:0]       overflow_total;
		logic [2:0]        failure_code;
	} item_t;

	typedef struct packed {
		logic [1:0]  health;
		logic        needs_recovery;
		logic        window_expired;
		logic [2:0]  latched_failure;
		logic [6:0]  fill_percent;
		logic [15:0] enter_count;
		logic [15:0] exit_count;
		logic [15:0] hard_count;
	} result_t;

endpackage

// ===== hdl/phm_state.sv =====
// ---------------------------------------------------------------------------
// phm_state
// Health state registers and the per-tick update logic.
// ---------------------------------------------------------------------------
`include "pipe_health_monitor_assert.svh"

module phm_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  phm_pkg::cfg_t   cfg,
	input  phm_pkg::item_t  item,
	output phm_pkg::result_t res
);

	logic [1:0]  health_q;
	logic        hard_q;
	logic        win_q;
	logic [31:0] start_q;
	logic [15:0] snap_q;
	logic [2:0]  ff_q;
	logic [15:0] enter_q;
	logic [15:0] exit_q;
	logic [15:0] hard_cnt_q;

	logic [phm_pkg::PROD_W-1:0] shifted;
	logic [6:0]  pct;
	logic        note_a, note_b, note, open_win;
	logic [2:0]  ff_a;
	logic [31:0] start_a;
	logic [15:0] snap_a;
	logic        win_a, hard_a;
	logic [31:0] elapsed;
	logic        over_a;

	logic [1:0]  health_n;
	logic        hard_n, win_n;
	logic [31:0] start_n;
	logic [15:0] snap_n;
	logic [2:0]  ff_n;
	logic [15:0] enter_n, exit_n, hard_cnt_n;
	logic        over_n, need;

	always_comb begin
		shifted = item.fill_x100 >> cfg.queue_size_log2;
		pct     = (shifted > phm_pkg::PROD_W'(phm_pkg::PCT_CAP)) ? phm_pkg::PCT_CAP
			: shifted[6:0];
	end

	// failure notes: a new code, or a latched code without hard mode
	always_comb begin
		note_a   = (item.failure_code != 3'd0);
		ff_a     = (ff_q == 3'd0 && note_a) ? item.failure_code : ff_q;
		note_b   = (ff_a != 3'd0) && !(hard_q || note_a);
		note     = note_a || note_b;
		open_win = note && !win_q;
		start_a  = open_win ? item.now_ms : start_q;
		snap_a   = open_win ? item.overflow_total : snap_q;
		win_a    = win_q || note;
		hard_a   = hard_q || note;
		elapsed  = item.now_ms - start_a;
		over_a   = win_a && (elapsed >= cfg.deadline_ms);
		hard_cnt_n = hard_cnt_q + 16'(note);
	end

	always_comb begin
		health_n = health_q;
		hard_n   = hard_a;
		win_n    = win_a;
		start_n  = start_a;
		snap_n   = snap_a;
		ff_n     = ff_a;
		enter_n  = enter_q;
		exit_n   = exit_q;
		priority if (ff_a != 3'd0) begin
			health_n = phm_pkg::HEALTH_HARD;
		end else if (hard_a) begin
			if (!over_a && !(item.overflow_total > snap_a) && pct < cfg.recovered_pct) begin
				hard_n   = 1'b0;
				win_n    = 1'b0;
				start_n  = 32'd0;
				snap_n   = 16'd0;
				ff_n     = 3'd0;
				health_n = phm_pkg::HEALTH_HEALTHY;
				exit_n   = exit_q + 16'd1;
			end else begin
				health_n = phm_pkg::HEALTH_HARD;
			end
		end else begin
			// hysteresis between healthy and distressed
			if (pct >= cfg.distressed_pct)
				health_n = phm_pkg::HEALTH_DISTRESSED;
			else if (health_q != phm_pkg::HEALTH_HEALTHY && pct < cfg.recovered_pct)
				health_n = phm_pkg::HEALTH_HEALTHY;
			if (health_q == phm_pkg::HEALTH_HEALTHY
					&& health_n == phm_pkg::HEALTH_DISTRESSED)
				enter_n = enter_q + 16'd1;
			else if (health_q == phm_pkg::HEALTH_DISTRESSED
					&& health_n == phm_pkg::HEALTH_HEALTHY)
				exit_n = exit_q + 16'd1;
		end
	end

	// a cleared window cannot be expired; otherwise expiry is the deadline check
	always_comb begin
		over_n = win_n && over_a;
		if (ff_n != 3'd0)
			need = 1'b1;
		else if (!win_n || !hard_n)
			need = 1'b0;
		else
			need = (item.overflow_total > snap_n) || over_n;
	end

	always_comb begin
		res.health          = health_n;
		res.needs_recovery  = need;
		res.window_expired  = over_n;
		res.latched_failure = ff_n;
		res.fill_percent    = pct;
		res.enter_count     = enter_n;
		res.exit_count      = exit_n;
		res.hard_count      = hard_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q   <= phm_pkg::HEALTH_HEALTHY;
			hard_q     <= 1'b0;
			win_q      <= 1'b0;
			start_q    <= 32'd0;
			snap_q     <= 16'd0;
			ff_q       <= 3'd0;
			enter_q    <= 16'd0;
			exit_q     <= 16'd0;
			hard_cnt_q <= 16'd0;
		end else if (step_en) begin
			health_q   <= health_n;
			hard_q     <= hard_n;
			win_q      <= win_n;
			start_q    <= start_n;
			snap_q     <= snap_n;
			ff_q       <= ff_n;
			enter_q    <= enter_n;
			exit_q     <= exit_n;
			hard_cnt_q <= hard_cnt_n;
		end
	end

	`PHM_ASSERT_NOW(a_latched_implies_hard, ff_q != 3'd0, hard_q,
		"latched failure without hard mode")
	`PHM_ASSERT_NOW(a_window_tracks_hard, 1'b1, win_q == hard_q,
		"degraded window and hard mode disagree")
	`PHM_ASSERT_NOW(a_hard_health, 1'b1, hard_q == (health_q == phm_pkg::HEALTH_HARD),
		"hard health code out of step with hard mode")
	`PHM_ASSERT_NEXT(a_idle_holds_counts, !step_en,
		$stable(hard_cnt_q) && $stable(enter_q) && $stable(exit_q),
		"counter moved without a transaction")

endmodule

// ===== hdl/pipe_health_monitor.sv =====
// ---------------------------------------------------------------------------
// pipe_health_monitor
// Capture pipeline health supervisor: failure latch, degraded window, hysteresis.
// ---------------------------------------------------------------------------
// One result transaction per accepted input transaction. The block takes one
// transaction every clock while the output is not stalled; the result passes
// through the input register, then the result register fed by the combinational
// state update in phm_state. While a result waits to be taken the input register
// can still take one more transaction, then in_ready stays low until the
// output moves. Write configuration only while no transaction is in flight.

module pipe_health_monitor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic [15:0] queue_fill,
	input  logic [15:0] overflow_total,
	input  logic [2:0]  failure_code,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  health,
	output logic        needs_recovery,
	output logic        window_expired,
	output logic [2:0]  latched_failure,
	output logic [6:0]  fill_percent,
	output logic [15:0] enter_count,
	output logic [15:0] exit_count,
	output logic [15:0] hard_count
);

	phm_pkg::cfg_t    cfg_q;
	phm_pkg::item_t   item_s1;
	logic             valid_s1;
	phm_pkg::result_t res;
	phm_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv;
	logic [phm_pkg::PROD_W-1:0] fill_x100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_size_log2 <= 4'd4;
			cfg_q.distressed_pct  <= 7'd75;
			cfg_q.recovered_pct   <= 7'd25;
			cfg_q.deadline_ms     <= 32'd5000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phm_pkg::CFG_QUEUE_SIZE_LOG2: cfg_q.queue_size_log2 <= cfg_data[3:0];
				phm_pkg::CFG_DISTRESSED_PCT:  cfg_q.distressed_pct  <= cfg_data[6:0];
				phm_pkg::CFG_RECOVERED_PCT:   cfg_q.recovered_pct   <= cfg_data[6:0];
				phm_pkg::CFG_DEADLINE_MS:     cfg_q.deadline_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	// fill * 100 as shifts and adds
	assign fill_x100 = {1'b0, queue_fill, 6'b0} + {2'b0, queue_fill, 5'b0}
		+ {5'b0, queue_fill, 2'b0};

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.now_ms         <= now_ms;
			item_s1.fill_x100      <= fill_x100;
			item_s1.overflow_total <= overflow_total;
			item_s1.failure_code   <= failure_code;
		end
		if (valid_s1 && adv)
			res_s2 <= res;
	end

	phm_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(valid_s1 && adv),
		.cfg    (cfg_q),
		.item   (item_s1),
		.res    (res)
	);

	assign out_valid       = valid_s2;
	assign health          = res_s2.health;
	assign needs_recovery  = res_s2.needs_recovery;
	assign window_expired  = res_s2.window_expired;
	assign latched_failure = res_s2.latched_failure;
	assign fill_percent    = res_s2.fill_percent;
	assign enter_count     = res_s2.enter_count;
	assign exit_count      = res_s2.exit_count;
	assign hard_count      = res_s2.hard_count;

endmodule
